### hdl/tcf_pkg.sv
// Package: texture cache constants, operation codes and the chain packet type.
package tcf_pkg;

	// Cache geometry
	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Field widths
	localparam int OP_W     = 2;
	localparam int KEY_W    = 64;
	localparam int CLUT_W   = 22;
	localparam int ADDR_W   = 32;
	localparam int HANDLE_W = 32;

	// Operation codes
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_INVAL  = 2'd2;
	localparam logic [OP_W-1:0] OP_FLUSH  = 2'd3;

	// Command plus running result, handed from cell to cell
	typedef struct packed {
		logic                vld;
		logic [OP_W-1:0]     op;
		logic [KEY_W-1:0]    key;
		logic [CLUT_W-1:0]   clut;
		logic                mode2;
		logic [ADDR_W-1:0]   start;
		logic [ADDR_W-1:0]   range_end;
		logic [HANDLE_W-1:0] handle;
		logic [IDX_W-1:0]    victim;
		logic                hit;
		logic [HANDLE_W-1:0] found;
	} pkt_t;

endpackage

### hdl/tcf_req_if.sv
// Interface: request channel carrying one cache operation per transaction.
interface tcf_req_if;
	logic                          valid;
	logic                          ready;
	logic [tcf_pkg::OP_W-1:0]      operation;
	logic [tcf_pkg::KEY_W-1:0]     tex_key;
	logic [tcf_pkg::CLUT_W-1:0]    clut_key;
	logic                          clut_mode2;
	logic [tcf_pkg::ADDR_W-1:0]    range_start;
	logic [tcf_pkg::ADDR_W-1:0]    range_size;
	logic [tcf_pkg::HANDLE_W-1:0]  handle;

	modport source (
		output valid, operation, tex_key, clut_key, clut_mode2, range_start, range_size,
			handle,
		input  ready
	);
	modport sink (
		input  valid, operation, tex_key, clut_key, clut_mode2, range_start, range_size,
			handle,
		output ready
	);
endinterface

### hdl/tcf_rsp_if.sv
// Interface: response channel carrying one lookup result per transaction.
interface tcf_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [tcf_pkg::HANDLE_W-1:0]  found_handle;

	modport source (
		output valid, hit, found_handle,
		input  ready
	);
	modport sink (
		input  valid, hit, found_handle,
		output ready
	);
endinterface

### hdl/tcf_cell.sv
// One cache entry: applies the passing command to its entry, forwards the packet.
module tcf_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic [tcf_pkg::IDX_W-1:0]  idx,
	input  tcf_pkg::pkt_t              pkt_in,
	output tcf_pkg::pkt_t              pkt_out
);

	logic [tcf_pkg::KEY_W-1:0]    key_q;
	logic [tcf_pkg::CLUT_W-1:0]   clut_q;
	logic                         mode2_q;
	logic [tcf_pkg::ADDR_W-1:0]   start_q;
	logic [tcf_pkg::ADDR_W-1:0]   end_q;
	logic [tcf_pkg::HANDLE_W-1:0] handle_q;
	tcf_pkg::pkt_t                pkt_q;
	tcf_pkg::pkt_t                pkt_nxt;

	logic entry_vld;
	logic key_match;
	logic start_in;
	logic end_in;
	logic wr_sel;
	logic clr;

	// Entry compare logic
	assign entry_vld = (handle_q != '0);
	assign key_match = entry_vld && (key_q == pkt_in.key) &&
		(!mode2_q || (clut_q == pkt_in.clut));
	assign start_in  = (pkt_in.start >= start_q) && (pkt_in.start < end_q);
	assign end_in    = (pkt_in.range_end >= start_q) && (pkt_in.range_end < end_q);
	assign wr_sel    = pkt_in.vld && (pkt_in.op == tcf_pkg::OP_INSERT) &&
		(pkt_in.victim == idx);

	// Handle clear for invalidate and flush
	always_comb begin
		clr = 1'b0;
		if (pkt_in.vld) begin
			case (pkt_in.op)
				tcf_pkg::OP_INVAL: clr = entry_vld && (start_in || end_in);
				tcf_pkg::OP_FLUSH: clr = 1'b1;
				default:           clr = 1'b0;
			endcase
		end
	end

	// First match along the chain wins
	always_comb begin
		pkt_nxt = pkt_in;
		if (pkt_in.vld && (pkt_in.op == tcf_pkg::OP_SEARCH) && !pkt_in.hit && key_match) begin
			pkt_nxt.hit   = 1'b1;
			pkt_nxt.found = handle_q;
		end
	end

	// Control state: handle (validity) and packet register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handle_q <= '0;
			pkt_q    <= '0;
		end else if (adv) begin
			pkt_q <= pkt_nxt;
			if (wr_sel) begin
				handle_q <= pkt_in.handle;
			end else if (clr) begin
				handle_q <= '0;
			end
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (adv && wr_sel) begin
			key_q   <= pkt_in.key;
			clut_q  <= pkt_in.clut;
			mode2_q <= pkt_in.mode2;
			start_q <= pkt_in.start;
			end_q   <= pkt_in.range_end;
		end
	end

	assign pkt_out = pkt_q;

endmodule

### hdl/texture_cache_fifo_lookup.sv
// Top level: fully associative texture cache built as a chain of entry cells.
//
//  channel | dir | transaction                               | payload
//  req     | in  | search / insert / invalidate / flush      | operation .. handle
//  rsp     | out | one result per request                    | hit, found_handle
//
// A request walks the cell chain one cell per cycle while the chain is not held;
// its result passes the ENTRIES cell registers, then lands in the output register.
// The next request is taken the cycle after the result is registered, so only one
// request is in the chain at a time; that result may still wait on rsp.
// The chain holds only while a finished result meets an unaccepted one on rsp.
// arst_n clears all handles (every entry invalid) and the victim pointer.
module texture_cache_fifo_lookup (
	input  logic       clk,
	input  logic       arst_n,
	tcf_req_if.sink    req,
	tcf_rsp_if.source  rsp
);

	logic                         busy_q;
	logic [tcf_pkg::IDX_W-1:0]    victim_q;
	logic                         rsp_vld_q;
	logic                         hit_q;
	logic [tcf_pkg::HANDLE_W-1:0] found_q;
	logic                         accept;
	logic                         adv;
	logic                         exit_vld;
	tcf_pkg::pkt_t                pkt [tcf_pkg::ENTRIES+1];

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign exit_vld  = pkt[tcf_pkg::ENTRIES].vld;
	// Chain holds only when a finished result cannot move into the output register
	assign adv       = !(exit_vld && rsp_vld_q && !rsp.ready);

	// Chain entry packet
	always_comb begin
		pkt[0].vld       = accept;
		pkt[0].op        = req.operation;
		pkt[0].key       = req.tex_key;
		pkt[0].clut      = req.clut_key;
		pkt[0].mode2     = req.clut_mode2;
		pkt[0].start     = req.range_start;
		pkt[0].range_end = req.range_start + req.range_size;
		pkt[0].handle    = req.handle;
		pkt[0].victim    = victim_q;
		pkt[0].hit       = 1'b0;
		pkt[0].found     = '0;
	end

	// Row of entry cells
	for (genvar i = 0; i < tcf_pkg::ENTRIES; i++) begin : g_cell
		tcf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.idx     (tcf_pkg::IDX_W'(i)),
			.pkt_in  (pkt[i]),
			.pkt_out (pkt[i+1])
		);
	end

	// Busy flag and round-robin victim pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			victim_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (exit_vld && adv) begin
				busy_q <= 1'b0;
			end
			if (accept && (req.operation == tcf_pkg::OP_INSERT)) begin
				if (victim_q == tcf_pkg::IDX_W'(tcf_pkg::ENTRIES - 1)) begin
					victim_q <= '0;
				end else begin
					victim_q <= victim_q + 1'b1;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (exit_vld && adv) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exit_vld && adv) begin
			hit_q   <= pkt[tcf_pkg::ENTRIES].hit;
			found_q <= pkt[tcf_pkg::ENTRIES].found;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.hit          = hit_q;
	assign rsp.found_handle = found_q;

	// A packet leaves the chain only while a request is outstanding
	a_exit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		exit_vld |-> busy_q)
		else $error("chain output without outstanding request");

	// A hit always carries a live (nonzero) handle
	a_hit_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(exit_vld && pkt[tcf_pkg::ENTRIES].hit) |-> (pkt[tcf_pkg::ENTRIES].found != '0))
		else $error("hit with zero handle");

	// Only searches can hit
	a_hit_search: assert property (@(posedge clk) disable iff (!arst_n)
		(exit_vld && (pkt[tcf_pkg::ENTRIES].op != tcf_pkg::OP_SEARCH))
		|-> !pkt[tcf_pkg::ENTRIES].hit)
		else $error("hit reported for non-search operation");

	// Victim pointer stays inside the table
	a_victim_range: assert property (@(posedge clk) disable iff (!arst_n)
		victim_q <= tcf_pkg::IDX_W'(tcf_pkg::ENTRIES - 1))
		else $error("victim pointer out of range");

	// Accepted request leaves busy set on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("busy not set after request accepted");

endmodule
